FILE: src/go_back_n_sender_window_defines.svh
// Assertion macros shared by the go-back-N sender window RTL.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define GBN_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define GBN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/gbn_win_pkg.sv
// Package for the go-back-N sender window: sizes, action and result codes,
// and the item and result records. No dependencies.
`default_nettype none

package gbn_win_pkg;

  localparam int WINDOW_SLOTS = 32;
  localparam int PAYLOAD_MAX  = 1024;
  localparam int BUFFER_BYTES = 65535;
  localparam int RESULT_CAP   = 32;
  localparam int WIN_CAP      = (WINDOW_SLOTS < RESULT_CAP) ? WINDOW_SLOTS : RESULT_CAP;
  localparam int SLOT_W       = $clog2(WINDOW_SLOTS);

  localparam int ACT_W  = 3;
  localparam int SEQ_W  = 16;
  localparam int CNT_W  = 16;
  localparam int LEN_W  = 11;
  localparam int WL_W   = 6;
  localparam int RCNT_W = $clog2(RESULT_CAP + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ACT_W-1:0] ACT_OFFER   = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_SEND    = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_ACK     = ACT_W'(2);
  localparam logic [ACT_W-1:0] ACT_FINACK  = ACT_W'(3);
  localparam logic [ACT_W-1:0] ACT_TIMEOUT = ACT_W'(4);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_OFFER,
    OP_SEND,
    OP_ACK,
    OP_FINACK,
    OP_TIMEOUT
  } op_t;

  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,
    KIND_NEW    = 2'd1,
    KIND_RESEND = 2'd2,
    KIND_FIN    = 2'd3
  } kind_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] offer_len;
    logic [SEQ_W-1:0] ack_number;
    logic [CNT_W-1:0] rx_window;
    logic             protocol_ok;
  } item_t;

  typedef struct packed {
    kind_t            kind;
    logic [SEQ_W-1:0] seq_number;
    logic [LEN_W-1:0] seg_bytes;
    logic [CNT_W-1:0] accepted_len;
    logic             xfer_done;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

FILE: src/gbn_win_front.sv
// Front end of the sender window: decodes the action of each incoming
// transaction and holds it in a two-entry queue. Depends on gbn_win_pkg.
`default_nettype none

module gbn_win_front import gbn_win_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [ACT_W-1:0] action,
  input  wire logic [CNT_W-1:0] offer_len,
  input  wire logic [SEQ_W-1:0] ack_number,
  input  wire logic [CNT_W-1:0] rx_window,
  input  wire logic             protocol_ok,
  output logic                  item_valid,
  output item_t                 item,
  input  wire logic             item_take
);

  item_t             q [QUEUE_DEPTH];
  item_t             incoming;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_take;

  always_comb begin
    incoming.offer_len   = offer_len;
    incoming.ack_number  = ack_number;
    incoming.rx_window   = rx_window;
    incoming.protocol_ok = protocol_ok;
    case (action)
      ACT_OFFER:   incoming.op = OP_OFFER;
      ACT_SEND:    incoming.op = OP_SEND;
      ACT_ACK:     incoming.op = OP_ACK;
      ACT_FINACK:  incoming.op = OP_FINACK;
      ACT_TIMEOUT: incoming.op = OP_TIMEOUT;
      default:     incoming.op = OP_NONE;
    endcase
  end

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign item_valid = (count != '0);
  assign item       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_take    = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_take})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/gbn_win_resq.sv
// Result queue of the sender window: two entries between the engine and
// the consumer. Depends on gbn_win_pkg.
`default_nettype none

module gbn_win_resq import gbn_win_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic res_valid,
  input  result_t   res,
  output logic      res_room,
  output logic      empty,
  input  wire logic pop,
  output result_t   head
);

  result_t           q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign res_room = (count != QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign head     = q[rd_ptr];
  assign do_wr    = res_valid && res_room;
  assign do_rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/gbn_win_back.sv
// Back end of the sender window: holds the connection state and the ring of
// segment lengths, and runs send passes and resends one result per cycle while
// the result queue has room. Depends on gbn_win_pkg and go_back_n_sender_window_defines.svh.
`default_nettype none

`include "go_back_n_sender_window_defines.svh"

module gbn_win_back import gbn_win_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic [WL_W-1:0] cfg_data,
  input  wire logic            item_valid,
  input  item_t                item,
  output logic                 item_take,
  input  wire logic            res_room,
  output logic                 res_valid,
  output result_t              res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_RESEND
  } state_t;

  state_t            state;
  logic [WL_W-1:0]   window_limit;
  logic [CNT_W-1:0]  buffered;
  logic [SEQ_W-1:0]  send_seq;
  logic [SEQ_W-1:0]  base_seq;
  logic              started;
  logic              paused;
  logic              fin_out;
  logic              done;
  logic [SEQ_W-1:0]  rs_seq;
  logic [RCNT_W-1:0] rs_cnt;
  logic [LEN_W-1:0]  slot_len [WINDOW_SLOTS];

  logic [WL_W-1:0]   eff_win;
  logic [SEQ_W-1:0]  inflight;
  logic [SEQ_W-1:0]  inflight_after;
  logic [SEQ_W-1:0]  skipped;
  logic              can_send;
  logic              more_after;
  logic              fin_ready;
  logic [LEN_W-1:0]  seg_len;
  logic [CNT_W-1:0]  buf_after;
  logic [CNT_W-1:0]  room;
  logic [CNT_W-1:0]  take;
  logic              rs_last;
  logic              emit;

  always_comb begin
    if (window_limit == '0) begin
      eff_win = WL_W'(1);
    end else if (window_limit > WL_W'(WIN_CAP)) begin
      eff_win = WL_W'(WIN_CAP);
    end else begin
      eff_win = window_limit;
    end
  end

  assign inflight       = send_seq - base_seq;
  assign inflight_after = inflight + SEQ_W'(1);
  assign skipped        = item.ack_number - base_seq;
  assign seg_len        = (buffered > CNT_W'(PAYLOAD_MAX)) ? LEN_W'(PAYLOAD_MAX)
                                                           : buffered[LEN_W-1:0];
  assign buf_after      = buffered - CNT_W'(seg_len);
  assign can_send       = (inflight < SEQ_W'(eff_win)) && (buffered != '0) && !paused;
  assign more_after     = (inflight_after < SEQ_W'(eff_win)) && (buf_after != '0) && !paused;
  assign fin_ready      = (buffered == '0) && (inflight == '0);
  assign room           = CNT_W'(BUFFER_BYTES) - buffered;
  assign take           = (item.offer_len > room) ? room : item.offer_len;
  assign rs_last        = ((rs_seq + SEQ_W'(1)) == send_seq)
                          || (rs_cnt == RCNT_W'(RESULT_CAP - 1));
  assign emit           = res_valid && res_room;

  always_comb begin
    item_take             = 1'b0;
    res_valid             = 1'b0;
    res.kind              = KIND_REPORT;
    res.seq_number        = '0;
    res.seg_bytes         = '0;
    res.accepted_len      = '0;
    res.xfer_done         = done;
    res.last              = 1'b1;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          case (item.op)
            OP_OFFER: begin
              res_valid        = 1'b1;
              res.accepted_len = take;
              item_take        = res_room;
            end
            OP_SEND: begin
              if (!done && !fin_out && started && !can_send && fin_ready) begin
                res_valid = 1'b1;
                res.kind  = KIND_FIN;
                item_take = res_room;
              end else begin
                item_take = 1'b1;
              end
            end
            OP_TIMEOUT: begin
              if (!done && fin_out) begin
                res_valid = 1'b1;
                res.kind  = KIND_FIN;
                item_take = res_room;
              end else begin
                item_take = 1'b1;
              end
            end
            default: item_take = 1'b1;
          endcase
        end
      end
      ST_SEND: begin
        res_valid      = 1'b1;
        res.kind       = KIND_NEW;
        res.seq_number = send_seq;
        res.seg_bytes  = seg_len;
        res.last       = !more_after;
      end
      ST_RESEND: begin
        res_valid      = 1'b1;
        res.kind       = KIND_RESEND;
        res.seq_number = rs_seq;
        res.seg_bytes  = slot_len[rs_seq[SLOT_W-1:0]];
        res.last       = rs_last;
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state == ST_SEND) && emit) begin
      slot_len[send_seq[SLOT_W-1:0]] <= seg_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_limit <= WL_W'(1);
      buffered     <= '0;
      send_seq     <= '0;
      base_seq     <= '0;
      started      <= 1'b0;
      paused       <= 1'b0;
      fin_out      <= 1'b0;
      done         <= 1'b0;
      rs_seq       <= '0;
      rs_cnt       <= '0;
    end else begin
      if (cfg_write) begin
        window_limit <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid && item_take) begin
            case (item.op)
              OP_OFFER: begin
                started  <= 1'b1;
                buffered <= buffered + take;
              end
              OP_SEND: begin
                if (!done && !fin_out && started) begin
                  if (can_send) begin
                    state <= ST_SEND;
                  end else if (fin_ready) begin
                    fin_out <= 1'b1;
                  end
                end
              end
              OP_ACK: begin
                if (!done && item.protocol_ok) begin
                  paused <= (item.rx_window == '0);
                  if (skipped <= inflight) begin
                    base_seq <= item.ack_number;
                  end
                end
              end
              OP_FINACK: begin
                if (!done && item.protocol_ok) begin
                  done <= 1'b1;
                end
              end
              OP_TIMEOUT: begin
                if (!done && !fin_out && (inflight != '0)) begin
                  state  <= ST_RESEND;
                  rs_seq <= base_seq;
                  rs_cnt <= '0;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_SEND: begin
          if (emit) begin
            buffered <= buf_after;
            send_seq <= send_seq + SEQ_W'(1);
            if (!more_after) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_RESEND: begin
          if (emit) begin
            rs_seq <= rs_seq + SEQ_W'(1);
            rs_cnt <= rs_cnt + RCNT_W'(1);
            if (rs_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `GBN_ASSERT_HOLDS(a_in_window, state == ST_SEND, inflight < SEQ_W'(eff_win), "over window")
  `GBN_ASSERT_NEXT(a_last_ends, emit && res.last && state != ST_IDLE, state == ST_IDLE, "run overran")
  `GBN_ASSERT_NEXT(a_done_sticks, done, done, "done flag cleared")
  `GBN_ASSERT_HOLDS(a_take_when_idle, item_take, state == ST_IDLE, "item taken while busy")

endmodule

`default_nettype wire

FILE: src/go_back_n_sender_window.sv
// Go-back-N sender window for one connection. Transactions enter through a
// two-entry queue (push/full), one engine carries them out in order, and
// results leave through a two-entry queue (empty/pop). An offer, ack, finack,
// unused action, or a send pass or timeout that gives no result or only FIN
// is done directly from idle; a send pass or timeout that emits segments is
// first dispatched, then emits them in turn, up to the window (at most 32).
// Every engine cycle that produces a result stalls while the result queue
// is full. Transactions are registered in the entry queue and results in
// the result queue; segments pass through the dispatch step first. The
// user must write the window_limit register through cfg_write/cfg_data only
// while no transaction is in flight; the block does not enforce this.
// Depends on gbn_win_pkg, gbn_win_front, gbn_win_back and gbn_win_resq.
`default_nettype none

module go_back_n_sender_window import gbn_win_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [WL_W-1:0]  cfg_data,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [ACT_W-1:0] action,
  input  wire logic [CNT_W-1:0] offer_len,
  input  wire logic [SEQ_W-1:0] ack_number,
  input  wire logic [CNT_W-1:0] rx_window,
  input  wire logic             protocol_ok,
  output logic                  empty,
  input  wire logic             pop,
  output logic [1:0]            kind,
  output logic [SEQ_W-1:0]      seq_number,
  output logic [LEN_W-1:0]      seg_bytes,
  output logic [CNT_W-1:0]      accepted_len,
  output logic                  xfer_done,
  output logic                  last
);

  logic    item_valid;
  item_t   item;
  logic    item_take;
  logic    res_valid;
  result_t res;
  logic    res_room;
  result_t head;

  gbn_win_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .offer_len   (offer_len),
    .ack_number  (ack_number),
    .rx_window   (rx_window),
    .protocol_ok (protocol_ok),
    .item_valid  (item_valid),
    .item        (item),
    .item_take   (item_take)
  );

  gbn_win_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_room   (res_room),
    .res_valid  (res_valid),
    .res        (res)
  );

  gbn_win_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_room  (res_room),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  assign kind         = head.kind;
  assign seq_number   = head.seq_number;
  assign seg_bytes    = head.seg_bytes;
  assign accepted_len = head.accepted_len;
  assign xfer_done    = head.xfer_done;
  assign last         = head.last;

endmodule

`default_nettype wire
